// ===== rtl/core/gedf_pkg.sv =====
// Shared types, constants and helpers for the global EDF scheduler.
`default_nettype none
package gedf_pkg;

  localparam int MAX_TASKS      = 16;
  localparam int MAX_PROCESSORS = 4;
  localparam int SLOT_W         = 4;
  localparam int PROC_W         = 2;
  localparam int USED_W         = 3;
  localparam int TIME_W         = 32;
  localparam int VAL_W          = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    PLACE_WAITING,
    PLACE_READY,
    PLACE_RUNNING
  } place_t;

  typedef struct packed {
    logic             op;
    logic [3:0]       task_slot;
    logic [VAL_W-1:0] budget;
    logic [VAL_W-1:0] first_release;
    logic [VAL_W-1:0] period_ticks;
    logic [VAL_W-1:0] relative_deadline;
  } item_t;

  typedef struct packed {
    logic [1:0] processor_index;
    logic [3:0] running_slot;
    logic       idle;
    logic       deadline_missed;
    logic       last;
  } result_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_RELEASE,
    DP_CHECK,
    DP_REARM_REL,
    DP_REARM_DUE,
    DP_SCAN,
    DP_ASSIGN,
    DP_RUN,
    DP_ADVANCE
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [SLOT_W-1:0] slot;
    logic [PROC_W-1:0] proc;
  } cmd_t;

  typedef struct packed {
    logic              proc_busy;
    logic              job_done;
    logic [USED_W-1:0] used;
  } status_t;

  // saturating add of a 16-bit step to a tick value
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W+1-VAL_W){1'b0}}, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gedf_ctrl.sv =====
// Tick sequencer: release sweep, processor check, per-proc scan/assign/run, advance.
`default_nettype none
module gedf_ctrl import gedf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    item_op,
  input  status_t      status,
  output logic         busy,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_REL, S_CHK, S_RA, S_RB, S_SCAN, S_ASG, S_RUN, S_FIN
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] sc;
  logic [PROC_W-1:0] pc;
  logic              accept;
  logic              last_proc;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign last_proc = ({1'b0, pc} + 3'd1) == status.used;

  // command decode from state
  always_comb begin
    cmd.slot = sc;
    cmd.proc = pc;
    unique case (state)
      S_IDLE:  cmd.op = (accept && item_op == OP_LOAD) ? DP_LOAD : DP_NOP;
      S_REL:   cmd.op = DP_RELEASE;
      S_CHK:   cmd.op = DP_CHECK;
      S_RA:    cmd.op = DP_REARM_REL;
      S_RB:    cmd.op = DP_REARM_DUE;
      S_SCAN:  cmd.op = DP_SCAN;
      S_ASG:   cmd.op = DP_ASSIGN;
      S_RUN:   cmd.op = DP_RUN;
      S_FIN:   cmd.op = DP_ADVANCE;
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sc    <= '0;
      pc    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          sc <= '0;
          pc <= '0;
          if (accept && item_op == OP_TICK) state <= S_REL;
        end
        S_REL: begin
          sc <= sc + 1'b1;
          if (sc == SLOT_W'(MAX_TASKS - 1)) state <= S_CHK;
        end
        // finished jobs re-arm; unfinished ones on dropped processors are handled inline
        S_CHK: begin
          if (status.proc_busy && status.job_done) begin
            state <= S_RA;
          end else if (pc == PROC_W'(MAX_PROCESSORS - 1)) begin
            pc    <= '0;
            sc    <= '0;
            state <= S_SCAN;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        S_RA: state <= S_RB;
        S_RB: begin
          if (pc == PROC_W'(MAX_PROCESSORS - 1)) begin
            pc    <= '0;
            sc    <= '0;
            state <= S_SCAN;
          end else begin
            pc    <= pc + 1'b1;
            state <= S_CHK;
          end
        end
        S_SCAN: begin
          sc <= sc + 1'b1;
          if (sc == SLOT_W'(MAX_TASKS - 1)) state <= S_ASG;
        end
        S_ASG: state <= S_RUN;
        S_RUN: begin
          sc <= '0;
          if (last_proc) begin
            state <= S_FIN;
          end else begin
            pc    <= pc + 1'b1;
            state <= S_SCAN;
          end
        end
        S_FIN:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gedf_dp.sv =====
// Task table, processor table, tick counter and per-command datapath.
`default_nettype none
module gedf_dp import gedf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  cmd_t                   cmd,
  input  item_t                  item,
  input  wire logic              cfg_we,
  input  wire logic [USED_W-1:0] cfg_data,
  output status_t                status,
  output logic                   result_valid,
  output result_t                result
);

  // per-slot state
  logic              active    [MAX_TASKS];
  place_t            place     [MAX_TASKS];
  logic [VAL_W-1:0]  remaining [MAX_TASKS];
  logic [VAL_W-1:0]  budget    [MAX_TASKS];
  logic [VAL_W-1:0]  period    [MAX_TASKS];
  logic [VAL_W-1:0]  reldl     [MAX_TASKS];
  logic [TIME_W-1:0] rel_at    [MAX_TASKS];
  logic [TIME_W-1:0] due       [MAX_TASKS];

  // per-processor state
  logic [SLOT_W-1:0] proc_slot [MAX_PROCESSORS];
  logic              proc_busy [MAX_PROCESSORS];

  logic [TIME_W-1:0] now;
  logic [USED_W-1:0] used_cfg;
  logic [USED_W-1:0] used;

  // scan state
  logic              best_valid;
  logic [SLOT_W-1:0] best_slot;
  logic [TIME_W-1:0] best_due;
  logic              missed;

  logic              use_proc;
  logic [SLOT_W-1:0] addr;
  logic              cand;
  logic              best_ok;
  logic              take;
  logic              pbusy;
  logic              preempt;
  logic [VAL_W-1:0]  rem_base;
  logic [TIME_W-1:0] new_rel;

  // clamp the processor count to 1..MAX_PROCESSORS
  always_comb begin
    priority if (used_cfg == '0) used = USED_W'(1);
    else if (used_cfg > USED_W'(MAX_PROCESSORS)) used = USED_W'(MAX_PROCESSORS);
    else used = used_cfg;
  end

  // one slot address per cycle: scan counter or the slot held by a processor
  assign use_proc = (cmd.op == DP_CHECK) || (cmd.op == DP_REARM_REL) ||
                    (cmd.op == DP_REARM_DUE) || (cmd.op == DP_ASSIGN) ||
                    (cmd.op == DP_RUN);
  assign addr     = use_proc ? proc_slot[cmd.proc] : cmd.slot;
  assign pbusy    = proc_busy[cmd.proc];

  assign status.proc_busy = pbusy;
  assign status.job_done  = (remaining[addr] == '0);
  assign status.used      = used;

  // earliest-deadline search, lowest index wins ties
  assign cand    = active[addr] && (place[addr] == PLACE_READY);
  assign best_ok = best_valid && (cmd.slot != '0);
  assign take    = cand && (!best_ok || (due[addr] < best_due));
  assign preempt = pbusy && best_valid && (best_due < due[addr]);

  assign rem_base = (remaining[addr] != '0) ? remaining[addr] :
                    ((budget[addr] != '0) ? budget[addr] : VAL_W'(1));
  assign new_rel  = sat_add(rel_at[addr], period[addr]);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        active[i]    <= 1'b0;
        place[i]     <= PLACE_WAITING;
        remaining[i] <= '0;
      end
      for (int p = 0; p < MAX_PROCESSORS; p++) begin
        proc_slot[p] <= '0;
        proc_busy[p] <= 1'b0;
      end
      now          <= '0;
      used_cfg     <= USED_W'(MAX_PROCESSORS);
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op == DP_RUN);
      if (cfg_we) used_cfg <= cfg_data;
      unique case (cmd.op)
        DP_LOAD: begin
          for (int p = 0; p < MAX_PROCESSORS; p++)
            if (proc_busy[p] && proc_slot[p] == item.task_slot) proc_busy[p] <= 1'b0;
          active[item.task_slot]    <= 1'b1;
          remaining[item.task_slot] <= '0;
          place[item.task_slot]     <= PLACE_WAITING;
        end
        DP_RELEASE: begin
          if (active[addr] && place[addr] == PLACE_WAITING && rel_at[addr] <= now)
            place[addr] <= PLACE_READY;
        end
        DP_CHECK: begin
          if (pbusy && remaining[addr] != '0 && {1'b0, cmd.proc} >= used) begin
            place[addr]         <= PLACE_READY;
            proc_busy[cmd.proc] <= 1'b0;
          end
        end
        DP_REARM_DUE: begin
          place[addr]         <= (rel_at[addr] <= now) ? PLACE_READY : PLACE_WAITING;
          proc_busy[cmd.proc] <= 1'b0;
        end
        DP_ASSIGN: begin
          if (preempt) begin
            place[addr]         <= PLACE_READY;
            proc_slot[cmd.proc] <= best_slot;
            place[best_slot]    <= PLACE_RUNNING;
          end else if (!pbusy && best_valid) begin
            proc_slot[cmd.proc] <= best_slot;
            proc_busy[cmd.proc] <= 1'b1;
            place[best_slot]    <= PLACE_RUNNING;
          end
        end
        DP_RUN: begin
          if (pbusy) remaining[addr] <= rem_base - 1'b1;
        end
        DP_ADVANCE: begin
          if (now != TIME_MAX) now <= now + 1'b1;
        end
        DP_NOP, DP_REARM_REL, DP_SCAN: ;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        budget[item.task_slot] <= item.budget;
        period[item.task_slot] <= item.period_ticks;
        reldl[item.task_slot]  <= item.relative_deadline;
        rel_at[item.task_slot] <= TIME_W'(item.first_release);
        due[item.task_slot]    <= sat_add(TIME_W'(item.first_release),
                                          item.relative_deadline);
      end
      DP_REARM_REL: rel_at[addr] <= new_rel;
      DP_REARM_DUE: due[addr] <= sat_add(rel_at[addr], reldl[addr]);
      DP_SCAN: begin
        if (cmd.slot == '0) best_valid <= take;
        else if (take) best_valid <= 1'b1;
        if (take) begin
          best_slot <= addr;
          best_due  <= due[addr];
        end
      end
      DP_ASSIGN: missed <= pbusy && (due[addr] <= now);
      DP_RUN: begin
        result.processor_index <= cmd.proc;
        result.running_slot    <= pbusy ? addr : '0;
        result.idle            <= !pbusy;
        result.deadline_missed <= missed;
        result.last            <= ({1'b0, cmd.proc} + 3'd1) == used;
      end
      DP_NOP, DP_RELEASE, DP_CHECK, DP_ADVANCE: ;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/global_edf_periodic_scheduler.sv =====
// Top level of the global EDF scheduler: sequencer plus task datapath.
//
// Usage: an item is taken at a clock edge with start high and busy low.
// A load item (op 0) writes one task slot in that cycle and gives no result;
// busy stays low. A tick item (op 1) raises busy and walks the task table:
// a release sweep over all slots, a check of every processor (one step, or
// three for a finished job that is re-armed), then per processor in use a
// deadline scan over all slots, an assign step and a run step, then one
// step to advance the tick counter. A tick's length grows with the number
// of processors in use, as slots are scanned one by one over the single
// table read port.
// Results: one beat per processor in use, processor 0 first, each shown on
// result for one cycle with result_valid high; the receiver cannot stall.
// Configuration: cfg_ready is always high; cfg_data sets processors_in_use.
// Write it only while busy is low. Reset clears all slots, processors and
// the tick counter and sets processors_in_use to 4.
`default_nettype none
module global_edf_periodic_scheduler import gedf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  item_t                  item,
  output logic                   result_valid,
  output result_t                result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [USED_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  gedf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item_op (item.op),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  gedf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire
